[rtl/ltfs_pkg.sv]
// Shared types, constants and operating-point table for the load-threshold frequency selector.
package ltfs_pkg;

  localparam int unsigned FREQ_W = 30;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned TEMP_W = 19;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned PROD_W = TIME_W + PCT_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OPP_MAX = 16;
  localparam int unsigned OPP_ENTRIES_DEF = 9;

  localparam logic [FREQ_W-1:0] BOOST_FREQ_HZ = FREQ_W'(944000000);
  localparam logic [PCT_W-1:0] UP_DEFAULT = PCT_W'(70);
  localparam logic [PCT_W-1:0] DOWN_DEFAULT = PCT_W'(30);
  localparam logic [PCT_W-1:0] PCT_SCALE = PCT_W'(100);
  localparam logic signed [TEMP_W-1:0] TLIMIT_DEFAULT = TEMP_W'(95000);

  // Operating points, highest first; unused slots are zero Hz.
  localparam logic [FREQ_W-1:0] OPP_TABLE [OPP_MAX] = '{
    FREQ_W'(891000000), FREQ_W'(835000000), FREQ_W'(720000000), FREQ_W'(640000000),
    FREQ_W'(525000000), FREQ_W'(490000000), FREQ_W'(400000000), FREQ_W'(305000000),
    FREQ_W'(150000000), FREQ_W'(0), FREQ_W'(0), FREQ_W'(0),
    FREQ_W'(0), FREQ_W'(0), FREQ_W'(0), FREQ_W'(0)
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP_PCT   = 3'd0,
    REG_DOWN_PCT = 3'd1,
    REG_MAX_FREQ = 3'd2,
    REG_MIN_FREQ = 3'd3,
    REG_TLIMIT   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    DEC_EMPTY   = 3'd0,
    DEC_BOOST   = 3'd1,
    DEC_UP      = 3'd2,
    DEC_DOWN    = 3'd3,
    DEC_HOLD    = 3'd4,
    DEC_THERMAL = 3'd5
  } decision_t;

  // Effective settings, with zero percentage and frequency registers already replaced by defaults.
  typedef struct packed {
    logic [PCT_W-1:0]         up_pct;
    logic [PCT_W-1:0]         down_pct;
    logic [FREQ_W-1:0]        fmax;
    logic [FREQ_W-1:0]        fmin;
    logic signed [TEMP_W-1:0] tlimit;
  } ltfs_cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]        busy_us;
    logic [TIME_W-1:0]        window_us;
    logic [FREQ_W-1:0]        current_freq_hz;
    logic                     boost_request;
    logic                     temp_valid;
    logic signed [TEMP_W-1:0] temperature_mdeg;
  } ltfs_item_t;

  typedef struct packed {
    decision_t                dec;
    logic [FREQ_W-1:0]        cand;
    logic                     temp_valid;
    logic signed [TEMP_W-1:0] temperature_mdeg;
  } ltfs_mid_t;

endpackage

[rtl/ltfs_cfg_regs.sv]
// Configuration registers with zero-means-default substitution for the percentage and frequency registers.
module ltfs_cfg_regs #(
  parameter int unsigned OPP_ENTRIES = ltfs_pkg::OPP_ENTRIES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ltfs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ltfs_pkg::FREQ_W-1:0]           cfg_data,
  output ltfs_pkg::ltfs_cfg_t                   cfg
);
  import ltfs_pkg::*;

  logic [PCT_W-1:0]         up_pct;
  logic [PCT_W-1:0]         down_pct;
  logic [FREQ_W-1:0]        max_lim;
  logic [FREQ_W-1:0]        min_lim;
  logic signed [TEMP_W-1:0] tlimit;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_pct   <= UP_DEFAULT;
      down_pct <= DOWN_DEFAULT;
      max_lim  <= '0;
      min_lim  <= '0;
      tlimit   <= TLIMIT_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_UP_PCT:   up_pct   <= cfg_data[PCT_W-1:0];
        REG_DOWN_PCT: down_pct <= cfg_data[PCT_W-1:0];
        REG_MAX_FREQ: max_lim  <= cfg_data;
        REG_MIN_FREQ: min_lim  <= cfg_data;
        REG_TLIMIT:   tlimit   <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.up_pct   = (up_pct == '0) ? UP_DEFAULT : up_pct;
    cfg.down_pct = (down_pct == '0) ? DOWN_DEFAULT : down_pct;
    cfg.fmax     = (max_lim == '0) ? OPP_TABLE[0] : max_lim;
    cfg.fmin     = (min_lim == '0) ? OPP_TABLE[OPP_ENTRIES-1] : min_lim;
    cfg.tlimit   = tlimit;
  end

endmodule

[rtl/ltfs_classify.sv]
// Load classification stage: picks the decision and the unsnapped candidate frequency.
module ltfs_classify (
  input  logic                 clk,
  input  logic                 rst,
  input  ltfs_pkg::ltfs_cfg_t  cfg,
  input  logic                 item_valid,
  input  ltfs_pkg::ltfs_item_t item,
  output logic                 ready,
  output logic                 mid_valid,
  output ltfs_pkg::ltfs_mid_t  mid,
  input  logic                 down_ready
);
  import ltfs_pkg::*;

  logic [PROD_W-1:0] busy_scaled;
  logic [PROD_W-1:0] total_up;
  logic [PROD_W-1:0] total_down;
  ltfs_mid_t         mid_next;

  assign ready = !mid_valid || down_ready;

  always_comb begin
    busy_scaled = PROD_W'(item.busy_us) * PROD_W'(PCT_SCALE);
    total_up    = PROD_W'(item.window_us) * PROD_W'(cfg.up_pct);
    total_down  = PROD_W'(item.window_us) * PROD_W'(cfg.down_pct);

    mid_next.temp_valid       = item.temp_valid;
    mid_next.temperature_mdeg = item.temperature_mdeg;
    if (item.window_us == '0) begin
      mid_next.dec  = DEC_EMPTY;
      mid_next.cand = cfg.fmax;
    end else if (item.boost_request) begin
      mid_next.dec  = DEC_BOOST;
      mid_next.cand = BOOST_FREQ_HZ;
    end else if (busy_scaled > total_up) begin
      mid_next.dec  = DEC_UP;
      mid_next.cand = cfg.fmax;
    end else if (busy_scaled < total_down) begin
      mid_next.dec  = DEC_DOWN;
      mid_next.cand = cfg.fmin;
    end else begin
      mid_next.dec  = DEC_HOLD;
      mid_next.cand = item.current_freq_hz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (ready) begin
      mid_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && item_valid) begin
      mid <= mid_next;
    end
  end

endmodule

[rtl/ltfs_finalize.sv]
// Final stage: operating-point snap, min/max clamp, thermal override and result register.
module ltfs_finalize #(
  parameter int unsigned OPP_ENTRIES = ltfs_pkg::OPP_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ltfs_pkg::ltfs_cfg_t          cfg,
  input  logic                         mid_valid,
  input  ltfs_pkg::ltfs_mid_t          mid,
  output logic                         ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ltfs_pkg::FREQ_W-1:0]  target_freq_hz,
  output logic [2:0]                   decision
);
  import ltfs_pkg::*;

  localparam int unsigned IDX_W = $clog2(OPP_ENTRIES);

  logic [FREQ_W-1:0] pts [OPP_ENTRIES];
  logic [OPP_ENTRIES-2:0] at_or_above;
  logic [IDX_W-1:0]  snap_idx;
  logic [FREQ_W-1:0] snapped;
  logic [FREQ_W-1:0] raised;
  logic [FREQ_W-1:0] freq_next;
  decision_t         dec_next;

  assign ready = !out_valid || !out_stall;

  // The table is sorted high to low, so the nearest point is found by comparing
  // twice the candidate against the sum of each neighboring pair. Ties keep the
  // higher point, since an equal distance satisfies the compare.
  always_comb begin
    for (int i = 0; i < OPP_ENTRIES; i++) begin
      pts[i] = OPP_TABLE[i];
    end
    for (int i = 0; i < OPP_ENTRIES - 1; i++) begin
      at_or_above[i] = {mid.cand, 1'b0} >=
                       ({1'b0, OPP_TABLE[i]} + {1'b0, OPP_TABLE[i+1]});
    end
    snap_idx = IDX_W'(OPP_ENTRIES - 1);
    for (int i = OPP_ENTRIES - 2; i >= 0; i--) begin
      if (at_or_above[i]) begin
        snap_idx = IDX_W'(i);
      end
    end
    snapped = pts[snap_idx];
    raised  = (snapped < cfg.fmin) ? cfg.fmin : snapped;

    if (mid.dec == DEC_EMPTY) begin
      freq_next = cfg.fmax;
      dec_next  = DEC_EMPTY;
    end else if (mid.temp_valid && (mid.temperature_mdeg > cfg.tlimit)) begin
      freq_next = cfg.fmin;
      dec_next  = DEC_THERMAL;
    end else begin
      freq_next = (raised > cfg.fmax) ? cfg.fmax : raised;
      dec_next  = mid.dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && mid_valid) begin
      target_freq_hz <= freq_next;
      decision       <= dec_next;
    end
  end

endmodule

[rtl/load_threshold_frequency_selector_top.sv]
// Top level of the load-threshold frequency selector: input register and stage wiring.
// Path: an accepted item passes the input register, then the classification register,
// then the result register. Throughput: one item per cycle while out_stall is low;
// each stage moves its item on whenever the next has room, so in_stall rises only
// when all three stages are full and out_stall is high.
// Reset (rst, synchronous, active high) empties the pipeline and restores the defaults.
module load_threshold_frequency_selector_top #(
  parameter int unsigned OPP_ENTRIES = ltfs_pkg::OPP_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [ltfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ltfs_pkg::FREQ_W-1:0]         cfg_data,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ltfs_pkg::TIME_W-1:0]         busy_us,
  input  logic [ltfs_pkg::TIME_W-1:0]         window_us,
  input  logic [ltfs_pkg::FREQ_W-1:0]         current_freq_hz,
  input  logic                                boost_request,
  input  logic                                temp_valid,
  input  logic signed [ltfs_pkg::TEMP_W-1:0]  temperature_mdeg,
  // Output channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ltfs_pkg::FREQ_W-1:0]         target_freq_hz,
  output logic [2:0]                          decision
);
  import ltfs_pkg::*;

  ltfs_cfg_t  cfg;
  ltfs_item_t item;
  logic       item_valid;
  logic       in_ready;
  logic       cls_ready;
  logic       fin_ready;
  logic       mid_valid;
  ltfs_mid_t  mid;

  // The input register accepts a new item whenever it is empty or its item moves on
  // into the classification stage in the same cycle.
  assign in_ready = !item_valid || cls_ready;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.busy_us          <= busy_us;
      item.window_us        <= window_us;
      item.current_freq_hz  <= current_freq_hz;
      item.boost_request    <= boost_request;
      item.temp_valid       <= temp_valid;
      item.temperature_mdeg <= temperature_mdeg;
    end
  end

  // Register file. Writes must arrive only while the pipeline is empty (the user's duty;
  // the block does not enforce it), so the stages read the effective settings directly.
  ltfs_cfg_regs #(
    .OPP_ENTRIES (OPP_ENTRIES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // First stage: the two threshold products and the decision.
  ltfs_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .ready      (cls_ready),
    .mid_valid  (mid_valid),
    .mid        (mid),
    .down_ready (fin_ready)
  );

  // Second stage: nearest operating point, clamp and thermal check.
  ltfs_finalize #(
    .OPP_ENTRIES (OPP_ENTRIES)
  ) u_finalize (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .mid_valid      (mid_valid),
    .mid            (mid),
    .ready          (fin_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .target_freq_hz (target_freq_hz),
    .decision       (decision)
  );

endmodule

[rtl/ltfs_checker.sv]
// Port-level checker for the load-threshold frequency selector and its bind.
module ltfs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ltfs_pkg::FREQ_W-1:0] target_freq_hz,
  input logic [2:0]                  decision
);
  import ltfs_pkg::*;

  // A stalled result keeps its value until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(target_freq_hz) && $stable(decision))
    else $error("stalled result changed or vanished");

  // Reset leaves no result pending.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  // The input side is held off only while a result is pending and the output is stalled.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid && out_stall)
    else $error("input stalled while the pipeline has room");

  // Once the output is free, an input stall cannot persist into the next cycle unless the output stalls again.
  assert property (@(posedge clk) disable iff (rst) !out_stall |=> !in_stall || out_stall)
    else $error("input stall held after the output drained");

endmodule

bind load_threshold_frequency_selector_top ltfs_checker u_ltfs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .target_freq_hz (target_freq_hz),
  .decision       (decision)
);
